// ----- hw/rtl/fcca_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the fat cluster chain allocator
// no dependencies; imported by fcca_sector and the top level

package fcca_pkg;

    // request kinds carried on the input tuser
    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_ALLOC  = 3'd1;
    localparam logic [2:0] REQ_EXTEND = 3'd2;
    localparam logic [2:0] REQ_NEXT   = 3'd3;
    localparam logic [2:0] REQ_SECTOR = 3'd4;

    // result status codes carried on the output tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RESERVED  = 2'd0;
    localparam logic [1:0] CFG_COPIES    = 2'd1;
    localparam logic [1:0] CFG_FAT_SIZE  = 2'd2;
    localparam logic [1:0] CFG_CLUS_SECS = 2'd3;

    // end-of-chain mark and the lowest word that counts as end of chain
    localparam logic [31:0] EOC_WORD   = 32'h0FFF_FFFF;
    localparam logic [27:0] EOC_MARK   = 28'hFFF_FFFF;
    localparam logic [31:0] EOC_LIMIT  = 32'h0FFF_FFF8;
    localparam logic [11:0] FIRST_DATA = 12'd2;

    // volume geometry used by the sector calculation
    typedef struct packed {
        logic [15:0] reserved_sectors;
        logic [7:0]  fat_copies;
        logic [31:0] fat_size_sectors;
        logic [7:0]  cluster_sectors;
    } t_sec_cfg;

endpackage

// ----- hw/rtl/fcca_sector.sv -----
`timescale 1ns / 1ps
// first-sector calculation: two-stage multiply then add
// depends on fcca_pkg (t_sec_cfg, FIRST_DATA)

module fcca_sector
    import fcca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_cluster_index,
    input  t_sec_cfg    i_cfg,
    output logic        o_valid,
    output logic [31:0] o_sector
);

    logic        r_v1;
    logic        r_v2;
    logic [15:0] r_rsv;
    logic [31:0] r_fat_area;
    logic [19:0] r_clus_off;
    logic [31:0] r_sector;
    logic [11:0] idx_m2;

    assign idx_m2 = i_cluster_index - FIRST_DATA;

    // valid flags of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    // stage one: the two products, stage two: the sum modulo 2^32
    always_ff @(posedge i_clk) begin
        r_rsv      <= i_cfg.reserved_sectors;
        r_fat_area <= 32'(i_cfg.fat_size_sectors * 32'(i_cfg.fat_copies));
        r_clus_off <= 20'(idx_m2) * 20'(i_cfg.cluster_sectors);
        r_sector   <= 32'(r_rsv) + r_fat_area + 32'(r_clus_off);
    end

    assign o_valid  = r_v2;
    assign o_sector = r_sector;

endmodule

// ----- hw/rtl/fat_cluster_chain_allocator_top.sv -----
`timescale 1ns / 1ps
// fat32 allocation table with chain allocate, extend, follow and sector lookup
// depends on fcca_pkg and fcca_sector
//
// Usage:
//   input stream: tuser = request kind, tdata = cluster index, cluster count and
//   the table word for a load. One result transaction is produced per request,
//   in request order, on the output stream (tdata = cluster and sector, tuser =
//   status). Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_wdata while no request is in flight.
//   Allocate and extend walk the table one word per cycle from cluster 2
//   through a single read port, so the length of the walk is set by how far
//   the last free word that is needed lies.
//   One request is worked on at a time; the next is taken as soon as the
//   previous result sits in the output register.
//   Reset: a clearing pass writes zero to every table word with tready low;
//   configuration writes are taken during it.
//   A stalled receiver holds the result in the output register; one more
//   request may be taken and finished, then the block waits for the slot.

module fat_cluster_chain_allocator_top
    import fcca_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // cluster_index[11:0], cluster_count[24:12], entry_value[56:25]
    input  logic [2:0]  i_s_axis_tuser,  // req_type[2:0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // result_cluster[27:0], start_sector[59:28]
    output logic [1:0]  o_m_axis_tuser,  // status[1:0]
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FIN   = 7'b0001000,
        S_NEXT  = 7'b0010000,
        S_SEC   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // control registers
    t_state       r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;
    logic         r_chk_v, n_chk_v;
    logic         r_alloc, n_alloc;
    logic         r_have_first, n_have_first;
    logic         r_full, n_full;
    logic [12:0]  r_done, n_done;
    logic         r_out_v, n_out_v;

    // payload registers
    logic [AW-1:0] r_chk, n_chk;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_first, n_first;
    logic [12:0]  r_target, n_target;
    logic [27:0]  r_res_cluster, n_res_cluster;
    logic [31:0]  r_res_sector, n_res_sector;
    logic [1:0]   r_res_status, n_res_status;
    logic [63:0]  r_out_data, n_out_data;
    logic [1:0]   r_out_user, n_out_user;

    t_sec_cfg     r_cfg;

    // table memory
    logic [31:0]  r_mem [TABLE_ENTRIES];
    logic [31:0]  r_rd_data;
    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]  mem_wdata;
    logic [AW-1:0] mem_raddr;

    // request fields
    logic         in_acc;
    logic [2:0]   in_type;
    logic [11:0]  in_idx;
    logic [12:0]  in_count;
    logic [31:0]  in_value;
    logic [31:0]  idx_ext;
    logic [AW-1:0] idx_addr;
    logic         idx_ok;
    logic [12:0]  done_inc;

    logic         sec_start;
    logic         sec_valid;
    logic [31:0]  sec_sector;

    assign in_type  = i_s_axis_tuser;
    assign in_idx   = i_s_axis_tdata[11:0];
    assign in_count = i_s_axis_tdata[24:12];
    assign in_value = i_s_axis_tdata[56:25];
    assign idx_ext  = 32'(in_idx);
    assign idx_addr = idx_ext[AW-1:0];
    assign idx_ok   = (in_idx >= FIRST_DATA) && (idx_ext < 32'(TABLE_ENTRIES));
    assign done_inc = r_done + 13'd1;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign sec_start       = in_acc && (in_type == REQ_SECTOR) && idx_ok;

    // sector calculation unit
    fcca_sector u_sector (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (sec_start),
        .i_cluster_index (in_idx),
        .i_cfg           (r_cfg),
        .o_valid         (sec_valid),
        .o_sector        (sec_sector)
    );

    // table memory, read data forwarded when the same word is written
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= (mem_we && (mem_waddr == mem_raddr)) ? mem_wdata : r_mem[mem_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reserved_sectors <= 16'd32;
            r_cfg.fat_copies       <= 8'd2;
            r_cfg.fat_size_sectors <= 32'd0;
            r_cfg.cluster_sectors  <= 8'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESERVED:  r_cfg.reserved_sectors <= i_cfg_wdata[15:0];
                CFG_COPIES:    r_cfg.fat_copies       <= i_cfg_wdata[7:0];
                CFG_FAT_SIZE:  r_cfg.fat_size_sectors <= i_cfg_wdata;
                CFG_CLUS_SECS: r_cfg.cluster_sectors  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // request sequencer
    always_comb begin
        n_state       = r_state;
        n_ptr         = r_ptr;
        n_chk_v       = 1'b0;
        n_chk         = r_ptr[AW-1:0];
        n_alloc       = r_alloc;
        n_have_first  = r_have_first;
        n_full        = r_full;
        n_done        = r_done;
        n_cur         = r_cur;
        n_first       = r_first;
        n_target      = r_target;
        n_res_cluster = r_res_cluster;
        n_res_sector  = r_res_sector;
        n_res_status  = r_res_status;
        n_out_v       = r_out_v && !i_m_axis_tready;
        n_out_data    = r_out_data;
        n_out_user    = r_out_user;
        mem_we        = 1'b0;
        mem_waddr     = r_cur;
        mem_wdata     = 32'd0;
        mem_raddr     = idx_addr;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                n_ptr     = r_ptr + PW'(1);
                if (r_ptr == PW'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res_cluster = '0;
                    n_res_sector  = '0;
                    n_res_status  = ST_OK;
                    n_state       = S_DONE;
                    n_full        = 1'b0;
                    n_have_first  = 1'b0;
                    n_done        = '0;
                    n_ptr         = PW'(FIRST_DATA);
                    unique case (in_type)
                        REQ_LOAD: begin
                            if (idx_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_addr;
                                mem_wdata = in_value;
                            end else begin
                                n_res_status = ST_RANGE;
                            end
                        end
                        REQ_ALLOC: begin
                            n_alloc  = 1'b1;
                            n_target = (in_count == 13'd0) ? 13'd1 : in_count;
                            n_state  = S_SCAN;
                        end
                        REQ_EXTEND: begin
                            if (idx_ok) begin
                                n_alloc  = 1'b0;
                                n_cur    = idx_addr;
                                n_target = in_count;
                                n_state  = (in_count == 13'd0) ? S_FIN : S_SCAN;
                            end else begin
                                n_res_status = ST_RANGE;
                            end
                        end
                        REQ_NEXT: begin
                            if (idx_ok) begin
                                n_state = S_NEXT;
                            end else begin
                                n_res_status = ST_RANGE;
                            end
                        end
                        REQ_SECTOR: begin
                            if (idx_ok) begin
                                n_state = S_SEC;
                            end else begin
                                n_res_status = ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // issue the next table read while the previous word is checked
                if (r_ptr < PW'(TABLE_ENTRIES)) begin
                    mem_raddr = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + PW'(1);
                    n_chk_v   = 1'b1;
                end
                if (r_chk_v) begin
                    if (r_rd_data == 32'd0) begin
                        n_done = done_inc;
                        n_cur  = r_chk;
                        if (r_alloc && !r_have_first) begin
                            n_first      = r_chk;
                            n_have_first = 1'b1;
                        end else begin
                            // link the previous chain end to the free word
                            mem_we    = 1'b1;
                            mem_waddr = r_cur;
                            mem_wdata = 32'(r_chk);
                        end
                        if (done_inc == r_target) begin
                            n_state = S_FIN;
                            n_chk_v = 1'b0;
                        end
                    end
                end else if (r_ptr >= PW'(TABLE_ENTRIES)) begin
                    // table exhausted
                    n_full = 1'b1;
                    if (r_alloc && !r_have_first) begin
                        n_res_cluster = '0;
                        n_res_status  = ST_FULL;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // close the chain
                mem_we        = 1'b1;
                mem_waddr     = r_cur;
                mem_wdata     = EOC_WORD;
                n_res_cluster = r_alloc ? 28'(r_first) : 28'(r_cur);
                n_res_status  = r_full ? ST_FULL : ST_OK;
                n_state       = S_DONE;
            end
            S_NEXT: begin
                n_res_cluster = (r_rd_data >= EOC_LIMIT) ? EOC_MARK : r_rd_data[27:0];
                n_state       = S_DONE;
            end
            S_SEC: begin
                if (sec_valid) begin
                    n_res_sector = sec_sector;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                // move the result into the output register once it is free
                if (!r_out_v || i_m_axis_tready) begin
                    n_out_v    = 1'b1;
                    n_out_data = {4'd0, r_res_sector, r_res_cluster};
                    n_out_user = r_res_status;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_ptr        <= '0;
            r_chk_v      <= 1'b0;
            r_alloc      <= 1'b0;
            r_have_first <= 1'b0;
            r_full       <= 1'b0;
            r_done       <= '0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_chk_v      <= n_chk_v;
            r_alloc      <= n_alloc;
            r_have_first <= n_have_first;
            r_full       <= n_full;
            r_done       <= n_done;
            r_out_v      <= n_out_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_chk         <= n_chk;
        r_cur         <= n_cur;
        r_first       <= n_first;
        r_target      <= n_target;
        r_res_cluster <= n_res_cluster;
        r_res_sector  <= n_res_sector;
        r_res_status  <= n_res_status;
        r_out_data    <= n_out_data;
        r_out_user    <= n_out_user;
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    // no request is taken while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("request accepted during table clear");

    // the scan never runs past the requested cluster count
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_done < r_target))
        else $error("scan link count reached target without closing");

    // a pending result waits while the output register is stalled
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_v && !i_m_axis_tready) |=> (r_state == S_DONE))
        else $error("result overwrote a stalled output");

    // sector unit answers only for a sector request in flight
    a_sec_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sec_valid |-> (r_state == S_SEC))
        else $error("sector result without a sector request");
`endif

endmodule
